/* src/khs_pkg.sv */
// Shared constants, payload types and control structs for the keyed handler stack.
package khs_pkg;

   localparam int STACK_DEPTH = 64;
   localparam int KEY_BITS    = 16;
   localparam int ID_BITS     = 32;

   localparam int KEY_W = (KEY_BITS < 16) ? KEY_BITS : 16;
   localparam int ID_W  = (ID_BITS < 32) ? ID_BITS : 32;
   localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int PTR_W = $clog2(STACK_DEPTH + 1);
   localparam int CMP_W = (PTR_W > 7) ? PTR_W : 7;

   localparam logic [1:0] OP_PUSH   = 2'd0;
   localparam logic [1:0] OP_POP    = 2'd1;
   localparam logic [1:0] OP_LOOKUP = 2'd2;
   localparam logic [1:0] OP_TRUNC  = 2'd3;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] cond_key;
      logic [31:0] handler_num;
      logic [63:0] handler_addr_in;
      logic [63:0] capture_in;
      logic [6:0]  new_depth;
   } req_type;

   typedef struct packed {
      logic        status;
      logic        found;
      logic [31:0] handler_num_out;
      logic [63:0] handler_addr_out;
      logic [63:0] capture_out;
      logic [6:0]  depth_now;
   } rsp_type;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [ID_W-1:0]  handler;
      logic [63:0]      addr;
      logic [63:0]      capture;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic accept;
      logic scan;
      logic shift;
      logic pop_done;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic hit;
      logic scan_end;
      logic shift_end;
      logic rsp_free;
   } stat_type;

endpackage

/* src/khs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module khs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* src/khs_ctrl.sv */
// Sequencer for the keyed handler stack: accept, search, shift, respond.
module khs_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [1:0]        req_kind,
   input  khs_pkg::stat_type stat,
   output logic              req_ready,
   output khs_pkg::cmd_type  cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SEARCH = 2'd1;
   localparam logic [1:0] ST_SHIFT  = 2'd2;
   localparam logic [1:0] ST_RESP   = 2'd3;

   logic [1:0] state_ff, state_in;
   logic [1:0] kind_ff, kind_in;

   always_comb begin
      state_in  = state_ff;
      kind_in   = kind_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               kind_in    = req_kind;
               if (req_kind == khs_pkg::OP_POP || req_kind == khs_pkg::OP_LOOKUP) begin
                  state_in = ST_SEARCH;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_SEARCH: begin
            cmd.scan = 1'b1;
            priority if (stat.hit) begin
               state_in = (kind_ff == khs_pkg::OP_POP) ? ST_SHIFT : ST_RESP;
            end else if (stat.scan_end) begin
               state_in = ST_RESP;
            end
         end
         ST_SHIFT: begin
            cmd.shift = 1'b1;
            if (stat.shift_end) begin
               cmd.pop_done = 1'b1;
               state_in     = ST_RESP;
            end
         end
         ST_RESP: begin
            if (stat.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      kind_ff <= kind_in;
   end

endmodule

/* src/khs_dp.sv */
// Datapath: entry RAM, depth and scan pointers, result and output registers.
module khs_dp (
   input  logic              clock,
   input  logic              reset,
   input  khs_pkg::req_type  req_data,
   input  khs_pkg::cmd_type  cmd,
   output khs_pkg::stat_type stat,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output khs_pkg::rsp_type  rsp_data
);

   localparam int IDX_W = khs_pkg::IDX_W;
   localparam int PTR_W = khs_pkg::PTR_W;
   localparam int CMP_W = khs_pkg::CMP_W;

   logic [PTR_W-1:0]         top_ff, top_in;
   logic [PTR_W-1:0]         ptr_ff, ptr_in;
   logic                     rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]         rd_idx_ff, rd_idx_in;
   logic [khs_pkg::KEY_W-1:0] key_ff, key_in;
   khs_pkg::rsp_type         res_ff, res_in;
   khs_pkg::rsp_type         rsp_ff, rsp_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   logic                          ram_we;
   logic [IDX_W-1:0]              ram_waddr, ram_raddr;
   logic [khs_pkg::ENTRY_W-1:0]   ram_wdata, ram_rdata;
   khs_pkg::entry_type            rd_entry, push_entry;

   logic             full, more;
   logic [CMP_W-1:0] nd_ext, top_ext;

   khs_ram #(
      .WIDTH (khs_pkg::ENTRY_W),
      .DEPTH (khs_pkg::STACK_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign rd_entry = khs_pkg::entry_type'(ram_rdata);
   assign full     = (top_ff == PTR_W'(khs_pkg::STACK_DEPTH));
   assign more     = (ptr_ff < top_ff);
   assign nd_ext   = CMP_W'(req_data.new_depth);
   assign top_ext  = CMP_W'(top_ff);

   always_comb begin
      push_entry.key     = khs_pkg::KEY_W'(req_data.cond_key);
      push_entry.handler = khs_pkg::ID_W'(req_data.handler_num);
      push_entry.addr    = req_data.handler_addr_in;
      push_entry.capture = req_data.capture_in;
   end

   always_comb begin
      stat.hit       = rd_vld_ff && (rd_entry.key == key_ff);
      stat.scan_end  = !rd_vld_ff && (ptr_ff == '0);
      stat.shift_end = !rd_vld_ff && !more;
      stat.rsp_free  = !rsp_valid_ff || rsp_ready;
   end

   // search walks down issuing one read a cycle; shift walks up moving each entry down one
   always_comb begin
      top_in       = top_ff;
      ptr_in       = ptr_ff;
      rd_vld_in    = rd_vld_ff;
      rd_idx_in    = rd_idx_ff;
      key_in       = key_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      ram_we       = 1'b0;
      ram_waddr    = IDX_W'(top_ff);
      ram_wdata    = push_entry;
      ram_raddr    = cmd.shift ? IDX_W'(ptr_ff) : IDX_W'(ptr_ff - PTR_W'(1));

      if (cmd.accept) begin
         key_in    = khs_pkg::KEY_W'(req_data.cond_key);
         ptr_in    = top_ff;
         rd_vld_in = 1'b0;
         res_in    = '0;
         if (req_data.kind == khs_pkg::OP_PUSH) begin
            if (full) begin
               res_in.status = 1'b1;
            end else begin
               ram_we = 1'b1;
               top_in = top_ff + PTR_W'(1);
            end
         end else if (req_data.kind == khs_pkg::OP_TRUNC) begin
            if (nd_ext <= top_ext) begin
               top_in = PTR_W'(nd_ext);
            end
         end
      end

      if (cmd.scan) begin
         priority if (stat.hit) begin
            res_in.found            = 1'b1;
            res_in.handler_num_out  = 32'(rd_entry.handler);
            res_in.handler_addr_out = rd_entry.addr;
            res_in.capture_out      = rd_entry.capture;
            ptr_in                  = PTR_W'(rd_idx_ff) + PTR_W'(1);
            rd_vld_in               = 1'b0;
         end else if (ptr_ff != '0) begin
            ptr_in    = ptr_ff - PTR_W'(1);
            rd_vld_in = 1'b1;
            rd_idx_in = IDX_W'(ptr_ff - PTR_W'(1));
         end else begin
            rd_vld_in = 1'b0;
         end
      end

      if (cmd.shift) begin
         if (rd_vld_ff) begin
            ram_we    = 1'b1;
            ram_waddr = rd_idx_ff - IDX_W'(1);
            ram_wdata = ram_rdata;
         end
         if (more) begin
            rd_vld_in = 1'b1;
            rd_idx_in = IDX_W'(ptr_ff);
            ptr_in    = ptr_ff + PTR_W'(1);
         end else begin
            rd_vld_in = 1'b0;
         end
      end

      if (cmd.pop_done) begin
         top_in = top_ff - PTR_W'(1);
      end

      priority if (cmd.load_rsp) begin
         rsp_in           = res_ff;
         rsp_in.depth_now = 7'(top_ff);
         rsp_valid_in     = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff       <= '0;
         ptr_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         top_ff       <= top_in;
         ptr_ff       <= ptr_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rd_idx_ff <= rd_idx_in;
      key_ff    <= key_in;
      res_ff    <= res_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* src/keyed_handler_stack.sv */
// Keyed handler stack: top level joining sequencer and datapath.
//
// Each word on the req_ channel is one operation: push, pop by key, lookup by
// key, or truncate to depth. Each operation returns exactly one word on the
// rsp_ channel, in order, carrying the depth after the operation.
// Push and truncate go from accept straight to the response state, which loads
// the output register once it is free.
// Lookup scans from the top, one entry per cycle through the entry RAM's
// registered read port. Pop adds a shift pass that moves every entry above
// the hit down one slot, one RAM read and one write per cycle, and the
// sequencer returns to idle before the next word is taken.
// One operation is in flight at a time; req_ready is high only when idle.
// The result sits in an output register, so the next word is accepted while
// an earlier result still waits on rsp_ready; a stalled receiver only holds
// the block once a second result is ready to be loaded.
// Reset empties the stack (depth zero); entry contents are not cleared and
// need no clearing pass, since only entries below the top are read.
module keyed_handler_stack (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  khs_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output khs_pkg::rsp_type rsp_data
);

   khs_pkg::cmd_type  cmd;
   khs_pkg::stat_type stat;

   khs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_data.kind),
      .stat      (stat),
      .req_ready (req_ready),
      .cmd       (cmd)
   );

   khs_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // a refused push only happens on a full stack and never reports a match
   a_refused_push_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status) |->
         (rsp_data.depth_now == 7'(khs_pkg::STACK_DEPTH)) && !rsp_data.found)
      else $error("refused push with stack not full or found set");

   a_miss_zero_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.found) |->
         (rsp_data.handler_num_out == '0) && (rsp_data.handler_addr_out == '0) &&
         (rsp_data.capture_out == '0))
      else $error("result data nonzero without a match");

   a_no_accept_while_busy: assert property (@(posedge clock) disable iff (reset)
      (cmd.scan || cmd.shift) |-> !req_ready)
      else $error("request accepted during search or shift");

endmodule
